// File: sv/f2i_pkg.sv
// Package for the float to integer converter.
// Holds register indexes, width codes and the stage payload types. No dependencies.
package f2i_pkg;
    localparam int unsigned AddrW = 4;
    localparam logic [1:0] RegFormat = 2'd0;
    localparam logic [1:0] RegWidth  = 2'd1;
    localparam logic [1:0] RegSigned = 2'd2;
    localparam logic [1:0] Width8  = 2'd0;
    localparam logic [1:0] Width16 = 2'd1;
    localparam logic [1:0] Width32 = 2'd2;
    localparam logic [1:0] Width64 = 2'd3;

    typedef struct packed {
        logic        dbl;
        logic [1:0]  wcode;
        logic        sgn;
    } t_cfg;

    typedef struct packed {
        logic        nan;
        logic        big;
        logic        neg;
        logic        zero;
        logic [63:0] sig;
        logic [6:0]  shl;
        logic [6:0]  shr;
        logic        left;
        logic        last;
        t_cfg        cfg;
    } t_s1;

    typedef struct packed {
        logic        nan;
        logic        big;
        logic        neg;
        logic [64:0] mag;
        logic        last;
        t_cfg        cfg;
    } t_s2;

    typedef struct packed {
        logic [63:0] res;
        logic        sat;
        logic        nan;
        logic        last;
    } t_s3;
endpackage

// File: sv/float_to_int_round_half_away.sv
// Float to integer converter, rounding half away from zero.
// Each input transfer is registered in r_s1, r_s2 and r_s3 in turn before it reaches the output.
// Throughput: one item per cycle; the pipeline advances when the output is free.
// Reset is synchronous, active low: clears valid bits and loads register defaults.
// Depends on f2i_pkg and f2i_core.
module float_to_int_round_half_away import f2i_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [63:0]      s_axis_tdata,  // value_bits
    input  logic             s_axis_tlast,  // last_in
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // int_result
    output logic [1:0]       m_axis_tuser,  // saturated, invalid
    output logic             m_axis_tlast,  // last_out
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    t_cfg r_cfg;
    logic en, cv;
    t_s3  cd;

    assign pready = 1'b1;
    assign en = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{dbl: 1'b0, wcode: Width32, sgn: 1'b1};
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            case (paddr[3:2])
                RegFormat: r_cfg.dbl <= pwdata[0];
                RegWidth:  r_cfg.wcode <= pwdata[1:0];
                RegSigned: r_cfg.sgn <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            RegFormat: prdata = {31'd0, r_cfg.dbl};
            RegWidth:  prdata = {30'd0, r_cfg.wcode};
            RegSigned: prdata = {31'd0, r_cfg.sgn};
            default:   prdata = '0;
        endcase
    end

    f2i_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(s_axis_tvalid),
        .i_bits(s_axis_tdata), .i_last(s_axis_tlast), .i_cfg(r_cfg),
        .o_valid(cv), .o_data(cd)
    );

    assign m_axis_tvalid = cv;
    assign m_axis_tdata = cd.res;
    assign m_axis_tuser = {cd.nan, cd.sat};
    assign m_axis_tlast = cd.last;
endmodule

// File: sv/f2i_core.sv
// Three-stage conversion datapath: unpack, shift and round, clamp.
// Depends on f2i_pkg.
module f2i_core import f2i_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_bits,
    input  logic        i_last,
    input  t_cfg        i_cfg,
    output logic        o_valid,
    output t_s3         o_data
);
    logic [2:0] r_v;
    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;

    always_comb begin
        logic [10:0] e;
        logic [51:0] f;
        logic signed [12:0] k;
        n_s1 = '0;
        n_s1.cfg = i_cfg;
        n_s1.last = i_last;
        if (i_cfg.dbl) begin
            n_s1.neg = i_bits[63];
            e = i_bits[62:52];
            f = i_bits[51:0];
            n_s1.nan = (e == 11'h7FF) && (f != '0);
            n_s1.big = (e == 11'h7FF) && (f == '0);
            n_s1.sig = {11'd0, 1'b1, f};
            k = $signed({2'b0, e}) - 13'sd1075;
            n_s1.big = n_s1.big || (e != 11'h7FF && k > 13'sd11);
        end else begin
            n_s1.neg = i_bits[31];
            e = {3'd0, i_bits[30:23]};
            f = {29'd0, i_bits[22:0]};
            n_s1.nan = (e == 11'hFF) && (f != '0);
            n_s1.big = (e == 11'hFF) && (f == '0);
            n_s1.sig = {40'd0, 1'b1, f[22:0]};
            k = $signed({2'b0, e}) - 13'sd150;
            n_s1.big = n_s1.big || (e != 11'hFF && k > 13'sd40);
        end
        n_s1.zero = (e == '0) || (!i_cfg.dbl && k < -13'sd24) || (i_cfg.dbl && k < -13'sd53);
        n_s1.left = (k >= 0);
        n_s1.shl = k[6:0];
        n_s1.shr = 7'(-k);
    end

    always_comb begin
        logic [63:0] q;
        logic        h;
        n_s2.nan = r_s1.nan;
        n_s2.big = r_s1.big;
        n_s2.neg = r_s1.neg;
        n_s2.last = r_s1.last;
        n_s2.cfg = r_s1.cfg;
        q = r_s1.sig >> r_s1.shr;
        h = r_s1.sig[6'(r_s1.shr - 7'd1)];
        if (r_s1.nan || r_s1.big || r_s1.zero) begin
            n_s2.mag = '0;
        end else if (r_s1.left) begin
            n_s2.mag = {1'b0, r_s1.sig << r_s1.shl[5:0]};
        end else begin
            n_s2.mag = {1'b0, q} + {64'd0, h};
        end
    end

    always_comb begin
        logic [63:0] lim, umax;
        logic        over;
        lim = 64'd1 << (7'd7 + (7'd8 << r_s2.cfg.wcode) - 7'd8);
        umax = (r_s2.cfg.wcode == Width64) ? '1 : ((lim << 1) - 64'd1);
        over = r_s2.big || r_s2.mag[64];
        n_s3.nan = r_s2.nan;
        n_s3.last = r_s2.last;
        n_s3.res = '0;
        n_s3.sat = 1'b0;
        if (!r_s2.nan) begin
            if (r_s2.cfg.sgn) begin
                if (!r_s2.neg) begin
                    if (over || r_s2.mag[63:0] > lim - 64'd1) begin
                        n_s3.res = lim - 64'd1;
                        n_s3.sat = 1'b1;
                    end else begin
                        n_s3.res = r_s2.mag[63:0];
                    end
                end else if (over || r_s2.mag[63:0] > lim) begin
                    n_s3.res = 64'd0 - lim;
                    n_s3.sat = 1'b1;
                end else begin
                    n_s3.res = 64'd0 - r_s2.mag[63:0];
                end
            end else if (r_s2.neg) begin
                n_s3.sat = over || (r_s2.mag != '0);
            end else if (over || r_s2.mag[63:0] > umax) begin
                n_s3.res = umax;
                n_s3.sat = 1'b1;
            end else begin
                n_s3.res = r_s2.mag[63:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
        if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_v[2];
    assign o_data = r_s3;
endmodule

// File: sv/f2i_checker.sv
// Port-level assertions for the float to integer converter.
// Depends on f2i_pkg; bound to float_to_int_round_half_away.
module f2i_assertions import f2i_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0 && !m_axis_tuser[0])
        else $error("invalid result not zero");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output changed");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while output empty");
endmodule

bind float_to_int_round_half_away f2i_assertions u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

// File: bench/f2i_checker.sv
// Scoreboard for the float to integer converter: tracks register writes, predicts each result
// from accepted input transfers and compares every output transfer field by field.
// Depends on f2i_pkg.
`timescale 1ns / 1ps
module f2i_checker import f2i_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [63:0]      s_axis_tdata,
    input  logic             s_axis_tlast,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [63:0]      m_axis_tdata,
    input  logic [1:0]       m_axis_tuser,
    input  logic             m_axis_tlast,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    input  logic             pready,
    output int               o_errors,
    output int               o_pending
);
    typedef struct {
        logic [63:0] value;
        logic        sat;
        logic        nan;
        logic        last;
    } t_int_result;

    t_int_result rounded_q[$];
    t_cfg        cfg;

    assign o_pending = rounded_q.size();

    function automatic t_int_result round_to_int(logic [63:0] bits, t_cfg c, logic last);
        t_int_result r;
        logic        neg;
        logic        big;
        logic [63:0] frac;
        logic [63:0] sig;
        logic [63:0] mag;
        logic [63:0] lim;
        logic [63:0] umax;
        int          expo;
        int          emax;
        int          fbits;
        int          bias;
        int          k;
        int          w;
        r = '{64'd0, 1'b0, 1'b0, last};
        big = 1'b0;
        mag = '0;
        if (c.dbl) begin
            neg = bits[63];
            expo = bits[62:52];
            frac = {12'd0, bits[51:0]};
            fbits = 52;
            emax = 2047;
            bias = 1075;
        end else begin
            neg = bits[31];
            expo = bits[30:23];
            frac = {41'd0, bits[22:0]};
            fbits = 23;
            emax = 255;
            bias = 150;
        end
        if (expo == emax && frac != 0) begin
            r.nan = 1'b1;
            return r;
        end
        if (expo == emax) begin
            big = 1'b1;
        end else if (expo != 0) begin
            sig = frac | (64'd1 << fbits);
            k = expo - bias;
            if (k >= 0) begin
                if (k > 64 - (fbits + 1)) big = 1'b1;
                else mag = sig << k;
            end else if (-k <= fbits + 1) begin
                mag = (sig >> (-k)) + ((sig >> (-k - 1)) & 64'd1);
            end
        end
        w = 8 << c.wcode;
        if (c.sgn) begin
            lim = 64'd1 << (w - 1);
            if (!neg) begin
                if (big || mag > lim - 1) begin
                    r.value = lim - 1;
                    r.sat = 1'b1;
                end else begin
                    r.value = mag;
                end
            end else begin
                if (big || mag > lim) begin
                    r.value = -lim;
                    r.sat = 1'b1;
                end else begin
                    r.value = -mag;
                end
            end
        end else begin
            umax = (w == 64) ? '1 : ((64'd1 << w) - 1);
            if (neg) begin
                r.sat = big || mag != 0;
            end else if (big || mag > umax) begin
                r.value = umax;
                r.sat = 1'b1;
            end else begin
                r.value = mag;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_int_result want;
        if (!i_rst_n) begin
            cfg <= '{dbl: 1'b0, wcode: Width32, sgn: 1'b1};
            o_errors = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    RegFormat: cfg.dbl <= pwdata[0];
                    RegWidth:  cfg.wcode <= pwdata[1:0];
                    RegSigned: cfg.sgn <= pwdata[0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                rounded_q.push_back(round_to_int(s_axis_tdata, cfg, s_axis_tlast));
            if (m_axis_tvalid && m_axis_tready) begin
                if (rounded_q.size() == 0) begin
                    report_mismatch("unexpected transfer", m_axis_tdata, 64'd0);
                end else begin
                    want = rounded_q.pop_front();
                    if (m_axis_tdata !== want.value)
                        report_mismatch("int_result", m_axis_tdata, want.value);
                    if (m_axis_tuser[0] !== want.sat)
                        report_mismatch("saturated", m_axis_tuser[0], want.sat);
                    if (m_axis_tuser[1] !== want.nan)
                        report_mismatch("invalid", m_axis_tuser[1], want.nan);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last_out", m_axis_tlast, want.last);
                end
            end
        end
    end
endmodule

// File: bench/tb_float_to_int_round_half_away.sv
// Testbench top for the float to integer converter: clock, reset, register writes and
// input and output traffic over all configurations; checking is done in f2i_checker.
// Depends on f2i_pkg, f2i_checker and float_to_int_round_half_away.
`timescale 1ns / 1ps
module tb_float_to_int_round_half_away;
    import f2i_pkg::*;

    localparam int StallLimit = 5000;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [63:0]      s_axis_tdata;   // value_bits
    logic             s_axis_tlast;   // last_in
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [63:0]      m_axis_tdata;   // int_result
    logic [1:0]       m_axis_tuser;   // saturated, invalid
    logic             m_axis_tlast;   // last_out
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;
    int               errors;
    int               pending;
    int               quiet_cycles;
    logic             calm;
    logic             hold_req;

    float_to_int_round_half_away i_dut (.*);

    f2i_checker i_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("tb_float_to_int_round_half_away: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int   hold;
        logic armed;
        m_axis_tready = 1'b0;
        hold = 0;
        armed = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_req) armed = 1'b0;
            if (hold_req && !armed) begin
                hold = 200;
                armed = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 18);
            end
        end
    end

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic send_value(logic [63:0] bits, logic last);
        if (!calm && $urandom_range(99) < 18) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= bits;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] pick_value(logic dbl, logic [1:0] wcode);
        logic [63:0] frac;
        logic [63:0] bits;
        logic        sgn;
        int          fbits;
        int          bias;
        int          e;
        int          p;
        fbits = dbl ? 52 : 23;
        bias = dbl ? 1023 : 127;
        frac = {$urandom, $urandom} & ((64'd1 << fbits) - 1);
        sgn = 1'($urandom_range(1));
        e = $urandom_range(2 * bias + 1);
        case ($urandom_range(9))
            0: begin
                e = 2 * bias + 1;
                if (frac == '0) frac = 64'd1;
            end
            1: begin
                e = 2 * bias + 1;
                frac = '0;
            end
            2: e = 0;
            3, 4: begin
                p = $urandom_range(fbits);
                e = bias + fbits - 1 - p;
                frac = frac & ~((64'd1 << (p + 1)) - 64'd1);
                if (p < fbits) frac = frac | (64'd1 << p);
            end
            5, 6: e = bias + (8 << wcode) - 3 + $urandom_range(3);
            7: e = bias - 2 + $urandom_range(fbits + 3);
            8: return {$urandom, $urandom};
            default: ;
        endcase
        if (dbl) bits = {sgn, e[10:0], frac[51:0]};
        else bits = {$urandom, sgn, e[7:0], frac[22:0]};
        return bits;
    endfunction

    initial begin
        logic [63:0] directed32[$];
        logic [63:0] directed64[$];
        int          phase;
        directed32 = '{64'h7FC0_0000, 64'h7F80_0000, 64'hFF80_0000, 64'h8000_0000,
                       64'h0000_0001, 64'h3F00_0000, 64'hBF00_0000, 64'h3EFF_FFFF,
                       64'h3FC0_0000, 64'hC020_0000, 64'h4F00_0000, 64'hCF00_0000,
                       64'hFFFF_FFFF_3F80_0000};
        directed64 = '{64'h7FF8_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                       64'h3FE0_0000_0000_0000, 64'h3FDF_FFFF_FFFF_FFFF,
                       64'h4330_0000_0000_0001, 64'h43E0_0000_0000_0000,
                       64'hC3E0_0000_0000_0000, 64'h3FE0_0000_0000_0001,
                       64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
                       64'h43F0_0000_0000_0000};
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed32[i]) send_value(directed32[i], i == directed32.size() - 1);
        s_axis_tvalid <= 1'b0;
        drain();
        write_reg(RegFormat, 32'd1);
        write_reg(RegWidth, {30'd0, Width64});
        write_reg(3, 32'hFFFF_FFFF);
        foreach (directed64[i]) send_value(directed64[i], i[0]);
        s_axis_tvalid <= 1'b0;
        drain();

        for (phase = 0; phase < 16; phase++) begin
            write_reg(RegFormat, {31'd0, phase[0]} | 32'hFFFF_FFFE);
            write_reg(RegWidth, {30'd0, phase[2:1]});
            write_reg(RegSigned, {31'd0, phase[3]});
            calm = (phase == 5);
            if (phase == 9) hold_req = 1'b1;
            repeat (108) send_value(pick_value(phase[0], phase[2:1]), 1'($urandom_range(1)));
            hold_req = 1'b0;
            s_axis_tvalid <= 1'b0;
            drain();
        end

        calm = 1'b0;
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_float_to_int_round_half_away: clean");
        end else begin
            $display("tb_float_to_int_round_half_away: errors");
        end
        $finish;
    end
endmodule
